// ===== sv/tgeb_pkg.sv =====
// ----------------------------------------------------------------------------
// Time-gated event builder package
// Field widths, register map and reset values shared by the event builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tgeb_pkg;

  localparam int unsigned TimeW    = 48;
  localparam int unsigned ChanW    = 4;
  localparam int unsigned EnergyW  = 16;
  localparam int unsigned TotalW   = 20;
  localparam int unsigned FiredW   = 4;
  localparam int unsigned EventW   = 32;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic RegTimeGate  = 1'b0;
  localparam logic RegFiredThr  = 1'b1;

  localparam logic [CfgW-1:0] TimeGateRst = 16'd200;
  localparam logic [CfgW-1:0] FiredThrRst = 16'd1;

  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};
  localparam logic [FiredW-1:0] FiredMax = {FiredW{1'b1}};

endpackage

`default_nettype wire

// ===== sv/time_gated_event_builder_core.sv =====
// ----------------------------------------------------------------------------
// Time-gated event builder core
// Groups time-ordered detector hits into events by a time window and reports
// each closed event's energy sum and fired count and the next event's start.
// ----------------------------------------------------------------------------
// The block takes one hit request in every clock cycle while in_ready_o is
// high and holds the result of an event-closing hit in its output register.
// The event-opening test, the latch update and the event summary are done in
// a single pass; the energy total is kept as a running sum as latches are
// overwritten, so closing an event costs only a saturation step.
`default_nettype none

module time_gated_event_builder_core #(
  parameter int unsigned CHANNELS = 9
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [tgeb_pkg::ApbAddrW-1:0]     paddr,
  input  wire logic [tgeb_pkg::ApbDataW-1:0]     pwdata,
  output logic      [tgeb_pkg::ApbDataW-1:0]     prdata,
  output logic                                   pready,

  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [tgeb_pkg::TimeW-1:0]        hit_time_i,
  input  wire logic [tgeb_pkg::ChanW-1:0]        channel_i,
  input  wire logic [tgeb_pkg::EnergyW-1:0]      energy_i,

  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [tgeb_pkg::TimeW-1:0]        event_start_o,
  output logic      [tgeb_pkg::TimeW-1:0]        start_gap_o,
  output logic      [tgeb_pkg::TotalW-1:0]       total_energy_o,
  output logic      [tgeb_pkg::FiredW-1:0]       fired_count_o,
  output logic      [tgeb_pkg::EventW-1:0]       event_number_o
);

  localparam int unsigned IdxW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SumW   = tgeb_pkg::EnergyW + $clog2(CHANNELS + 1);
  localparam int unsigned CntW   = $clog2(CHANNELS + 1);
  localparam int unsigned SatSW  = (SumW > tgeb_pkg::TotalW) ? SumW : tgeb_pkg::TotalW;
  localparam int unsigned SatCW  = (CntW > tgeb_pkg::FiredW) ? CntW : tgeb_pkg::FiredW;
  localparam int unsigned StartW = tgeb_pkg::TimeW + 1;
  localparam int unsigned DiffW  = tgeb_pkg::TimeW + 2;

  logic [tgeb_pkg::CfgW-1:0]    gate_q, gate_d;
  logic [tgeb_pkg::CfgW-1:0]    thr_q, thr_d;
  logic [StartW-1:0]            start_q, start_d;
  logic                         armed_q, armed_d;
  logic [tgeb_pkg::EnergyW-1:0] latch_q [CHANNELS];
  logic [tgeb_pkg::EnergyW-1:0] latch_d [CHANNELS];
  logic [SumW-1:0]              total_q, total_d;
  logic [tgeb_pkg::EventW-1:0]  events_q, events_d;

  logic                         out_valid_q, out_valid_d;
  logic [tgeb_pkg::TimeW-1:0]   ev_start_q;
  logic [tgeb_pkg::TimeW-1:0]   gap_q;
  logic [tgeb_pkg::TotalW-1:0]  tot_q;
  logic [tgeb_pkg::FiredW-1:0]  fired_q;
  logic [tgeb_pkg::EventW-1:0]  num_q;

  logic                         cfg_wr;
  logic                         cfg_idx;
  logic                         accept;
  logic                         in_range;
  logic [IdxW-1:0]              idx;
  logic [tgeb_pkg::EnergyW-1:0] old_energy;
  logic signed [DiffW-1:0]      diff;
  logic                         opens;
  logic                         emit;
  logic [CntW-1:0]              fired_cnt;
  logic [SatSW-1:0]             tot_ext;
  logic [SatCW-1:0]             cnt_ext;
  logic [tgeb_pkg::TotalW-1:0]  tot_sat;
  logic [tgeb_pkg::FiredW-1:0]  cnt_sat;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      tgeb_pkg::RegTimeGate: prdata = tgeb_pkg::ApbDataW'(gate_q);
      tgeb_pkg::RegFiredThr: prdata = tgeb_pkg::ApbDataW'(thr_q);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    gate_d = gate_q;
    thr_d  = thr_q;
    if (cfg_wr) begin
      case (cfg_idx)
        tgeb_pkg::RegTimeGate: gate_d = pwdata[tgeb_pkg::CfgW-1:0];
        tgeb_pkg::RegFiredThr: thr_d  = pwdata[tgeb_pkg::CfgW-1:0];
        default: begin
          gate_d = gate_q;
          thr_d  = thr_q;
        end
      endcase
    end
  end

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign accept     = in_valid_i & in_ready_o;

  assign in_range   = 32'(channel_i) < CHANNELS;
  assign idx        = IdxW'(channel_i);
  assign old_energy = in_range ? latch_q[idx] : '0;

  assign diff  = $signed({2'b00, hit_time_i}) - $signed({start_q[StartW-1], start_q});
  assign opens = ~diff[DiffW-1] && (diff[DiffW-2:0] > (DiffW-1)'(gate_q));
  assign emit  = opens & armed_q;

  always_comb begin
    fired_cnt = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      fired_cnt = fired_cnt + CntW'(latch_q[i] > thr_q);
    end
  end

  assign tot_ext = SatSW'(total_q);
  assign cnt_ext = SatCW'(fired_cnt);
  assign tot_sat = (tot_ext > SatSW'(tgeb_pkg::TotalMax)) ? tgeb_pkg::TotalMax
                                                          : tot_ext[tgeb_pkg::TotalW-1:0];
  assign cnt_sat = (cnt_ext > SatCW'(tgeb_pkg::FiredMax)) ? tgeb_pkg::FiredMax
                                                          : cnt_ext[tgeb_pkg::FiredW-1:0];

  always_comb begin
    start_d  = start_q;
    armed_d  = armed_q;
    total_d  = total_q;
    events_d = events_q;
    for (int i = 0; i < CHANNELS; i++) begin
      latch_d[i] = latch_q[i];
    end
    if (accept) begin
      if (opens) begin
        start_d = {1'b0, hit_time_i};
        armed_d = 1'b1;
      end
      if (emit) begin
        events_d = events_q + 1'b1;
        for (int i = 0; i < CHANNELS; i++) begin
          latch_d[i] = '0;
        end
        total_d = '0;
        if (in_range) begin
          latch_d[idx] = energy_i;
          total_d      = SumW'(energy_i);
        end
      end else if (!opens && in_range) begin
        latch_d[idx] = energy_i;
        total_d      = total_q - SumW'(old_energy) + SumW'(energy_i);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q      <= tgeb_pkg::TimeGateRst;
      thr_q       <= tgeb_pkg::FiredThrRst;
      start_q     <= '1;
      armed_q     <= 1'b0;
      total_q     <= '0;
      events_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        latch_q[i] <= '0;
      end
    end else begin
      gate_q      <= gate_d;
      thr_q       <= thr_d;
      start_q     <= start_d;
      armed_q     <= armed_d;
      total_q     <= total_d;
      events_q    <= events_d;
      out_valid_q <= out_valid_d;
      for (int i = 0; i < CHANNELS; i++) begin
        latch_q[i] <= latch_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      ev_start_q <= hit_time_i;
      gap_q      <= diff[tgeb_pkg::TimeW-1:0];
      tot_q      <= tot_sat;
      fired_q    <= cnt_sat;
      num_q      <= events_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_start_o  = ev_start_q;
  assign start_gap_o    = gap_q;
  assign total_energy_o = tot_q;
  assign fired_count_o  = fired_q;
  assign event_number_o = num_q;

endmodule

`default_nettype wire
